// ----- src/mrlf_pkg.sv -----
// ----------------------------------------------------------------------------
// mrlf_pkg
// Types, constants and the control program of the length factorizer.
// ----------------------------------------------------------------------------
package mrlf_pkg;

  localparam int NUM_REGS      = 6;
  localparam int MAX_RADICES   = 8;
  localparam int IDX_W         = 3;
  localparam int RADIX_W       = 8;
  localparam int COUNT_W       = 5;
  localparam int OUT_LEN_W     = 31;
  localparam int DIV_STEP_BITS = 4;
  localparam int STEP_W        = 3;

  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [STEP_W-1:0]  step_t;

  localparam radix_t RADIX_MIN = 8'd2;
  localparam radix_t RADIX_RESET [MAX_RADICES] = '{
    8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19
  };

  // jump conditions
  typedef enum logic [2:0] {
    C_NEXT     = 3'd0,
    C_ALWAYS   = 3'd1,
    C_IDLE     = 3'd2,
    C_DIV_BUSY = 3'd3,
    C_NO_DIV   = 3'd4,
    C_LAST     = 3'd5
  } cond_t;

  // program addresses
  localparam step_t S_IDLE   = 3'd0;
  localparam step_t S_RINIT  = 3'd1;
  localparam step_t S_DSTART = 3'd2;
  localparam step_t S_DWAIT  = 3'd3;
  localparam step_t S_TEST   = 3'd4;
  localparam step_t S_TAKE   = 3'd5;
  localparam step_t S_EMIT   = 3'd6;
  localparam step_t S_ADV    = 3'd7;

  typedef struct packed {
    logic  load_len;
    logic  load_radix;
    logic  div_start;
    logic  take_quot;
    logic  emit;
    logic  next_idx;
    cond_t cond;
    step_t target;
  } ctl_t;

  function automatic ctl_t ucode(step_t s);
    ctl_t w;
    w = '0;
    w.cond   = C_NEXT;
    w.target = S_IDLE;
    case (s)
      S_IDLE: begin
        w.load_len = 1'b1;
        w.cond     = C_IDLE;
        w.target   = S_IDLE;
      end
      S_RINIT: begin
        w.load_radix = 1'b1;
      end
      S_DSTART: begin
        w.div_start = 1'b1;
      end
      S_DWAIT: begin
        w.cond   = C_DIV_BUSY;
        w.target = S_DWAIT;
      end
      S_TEST: begin
        w.cond   = C_NO_DIV;
        w.target = S_EMIT;
      end
      S_TAKE: begin
        w.take_quot = 1'b1;
        w.cond      = C_ALWAYS;
        w.target    = S_DSTART;
      end
      S_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = C_LAST;
        w.target = S_IDLE;
      end
      S_ADV: begin
        w.next_idx = 1'b1;
        w.cond     = C_ALWAYS;
        w.target   = S_RINIT;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- src/mrlf_div.sv -----
// ----------------------------------------------------------------------------
// mrlf_div
// Iterative restoring divider, length by 8-bit radix, several bits per cycle.
// ----------------------------------------------------------------------------
module mrlf_div
  import mrlf_pkg::*;
#(
  parameter int LENGTH_WIDTH = 31
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [LENGTH_WIDTH-1:0] dividend,
  input  radix_t                  divisor,
  output logic                    busy,
  output logic [LENGTH_WIDTH-1:0] quotient,
  output radix_t                  remainder
);

  localparam int ITER = (LENGTH_WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int PW   = ITER * DIV_STEP_BITS;
  localparam int CW   = $clog2(ITER + 1);

  logic [PW-1:0] quot;
  logic [PW-1:0] quot_next;
  radix_t        rem;
  radix_t        rem_next;
  logic [CW-1:0] cnt;

  always_comb begin
    logic [RADIX_W:0] part;
    logic [PW-1:0]    q_v;
    radix_t           r_v;
    q_v = quot;
    r_v = rem;
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      part = {r_v, q_v[PW-1]};
      q_v  = {q_v[PW-2:0], 1'b0};
      if (part >= {1'b0, divisor}) begin
        part   = part - {1'b0, divisor};
        q_v[0] = 1'b1;
      end
      r_v = part[RADIX_W-1:0];
    end
    quot_next = q_v;
    rem_next  = r_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(ITER);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= PW'(dividend);
      rem  <= '0;
    end else if (cnt != '0) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

  assign busy      = (cnt != '0);
  assign quotient  = quot[LENGTH_WIDTH-1:0];
  assign remainder = rem;

endmodule

// ----- src/mixed_radix_length_factorizer_core.sv -----
// ----------------------------------------------------------------------------
// mixed_radix_length_factorizer_core
// Divides each configured radix out of a transform length, one result per radix.
// ----------------------------------------------------------------------------
//  channel   direction  transfer when          payload
//  command   in         start & !busy          fft_length
//  result    out        result_valid (1 cyc)   radix_index radix_count remaining_length
//                                              leftover_factor invalid_length last_result
//  config    in         cfg_write              cfg_index cfg_data
//
//  a microcode program steps a shared divider that retires 4 bits a cycle
//  rst is synchronous and restores the default radices
//  results cannot be stalled; busy is high until the last result is shown
// ----------------------------------------------------------------------------
module mixed_radix_length_factorizer_core
  import mrlf_pkg::*;
#(
  parameter int NUM_RADICES  = 6,
  parameter int LENGTH_WIDTH = 31
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [LENGTH_WIDTH-1:0] fft_length,
  input  logic                    cfg_write,
  input  logic [IDX_W-1:0]        cfg_index,
  input  radix_t                  cfg_data,
  output logic                    result_valid,
  output logic [IDX_W-1:0]        radix_index,
  output logic [COUNT_W-1:0]      radix_count,
  output logic [OUT_LEN_W-1:0]    remaining_length,
  output logic [OUT_LEN_W-1:0]    leftover_factor,
  output logic                    invalid_length,
  output logic                    last_result
);

  step_t                   step;
  step_t                   step_next;
  ctl_t                    ctl;
  logic                    jump;
  logic [LENGTH_WIDTH-1:0] rem;
  logic                    invalid;
  logic [IDX_W-1:0]        idx;
  logic [COUNT_W-1:0]      count;
  radix_t                  radix;
  radix_t                  radix_next;
  radix_t                  radix_regs [MAX_RADICES];
  logic                    last;
  logic                    div_busy;
  logic [LENGTH_WIDTH-1:0] div_quot;
  radix_t                  div_rem;
  logic [LENGTH_WIDTH+OUT_LEN_W-1:0] rem_ext;
  logic [OUT_LEN_W-1:0]    rem_out;

  assign ctl  = ucode(step);
  assign busy = (step != S_IDLE);
  assign last = (idx == IDX_W'(NUM_RADICES - 1));

  always_comb begin
    case (ctl.cond)
      C_NEXT:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_IDLE:     jump = !start;
      C_DIV_BUSY: jump = div_busy;
      C_NO_DIV:   jump = invalid || (div_rem != '0);
      C_LAST:     jump = last;
      default:    jump = 1'b0;
    endcase
    step_next = jump ? ctl.target : step + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // radix registers, fixed radices past the configurable ones
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_regs <= RADIX_RESET;
    end else if (cfg_write && (cfg_index < IDX_W'(NUM_REGS))) begin
      radix_regs[cfg_index] <= cfg_data;
    end
  end

  assign radix_next = (radix_regs[idx] < RADIX_MIN) ? RADIX_MIN : radix_regs[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (ctl.load_len && start) begin
      idx <= '0;
    end else if (ctl.next_idx) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_len && start) begin
      rem     <= fft_length;
      invalid <= (fft_length == '0);
    end else if (ctl.take_quot) begin
      rem <= div_quot;
    end
    if (ctl.load_radix) begin
      radix <= radix_next;
      count <= '0;
    end else if (ctl.take_quot) begin
      count <= count + 1'b1;
    end
  end

  mrlf_div #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (rem),
    .divisor  (radix),
    .busy     (div_busy),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  assign rem_ext = {{OUT_LEN_W{1'b0}}, rem};
  assign rem_out = rem_ext[OUT_LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      radix_index      <= idx;
      radix_count      <= count;
      remaining_length <= invalid ? '0 : rem_out;
      leftover_factor  <= (last && !invalid) ? rem_out : '0;
      invalid_length   <= invalid;
      last_result      <= last;
    end
  end

endmodule

// ----- sim/tb_mixed_radix_length_factorizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mixed_radix_length_factorizer_core
// Self-checking bench for the length factorizer. A driver pulls lengths from
// a queue, a local predictor divides out the current radix table to build the
// six expected results per length, and a monitor checks each result strobe
// field by field. Radix registers are reprogrammed between phases, covering
// defaults, values below two, the top value, unused indexes and random sets.
// ----------------------------------------------------------------------------
module tb_mixed_radix_length_factorizer_core;
  import mrlf_pkg::*;

  localparam int          LEN_W       = 31;
  localparam int          RES_PER_LEN = 6;
  localparam longint      LEN_LIMIT   = 64'h8000_0000;
  localparam int          IDLE_LIMIT  = 4000;
  localparam int          RAND_PHASES = 7;
  localparam int          RAND_ITEMS  = 55;

  typedef enum logic [IDX_W-1:0] {
    REG_RADIX_A, REG_RADIX_B, REG_RADIX_C, REG_RADIX_D,
    REG_RADIX_E, REG_RADIX_F, REG_SPARE_6, REG_SPARE_7
  } reg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0]     idx;
    logic [COUNT_W-1:0]   count;
    logic [OUT_LEN_W-1:0] remain;
    logic [OUT_LEN_W-1:0] leftover;
    logic                 invalid;
    logic                 last;
  } factor_result_t;

  localparam int unsigned DIRECTED_DEFAULT [16] = '{
    0, 1, 2, 2147483647, 1073741824, 1162261467, 1220703125, 1977326743,
    214358881, 815730721, 30030, 2147483646, 510510, 323, 1610612736, 1031
  };
  localparam int unsigned DIRECTED_ODD [9] = '{
    0, 1, 16581375, 64770, 1073741824, 2147483647, 1020, 254, 255
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [LEN_W-1:0]     fft_length = '0;
  logic                 cfg_write = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  radix_t               cfg_data = '0;
  logic                 result_valid;
  logic [IDX_W-1:0]     radix_index;
  logic [COUNT_W-1:0]   radix_count;
  logic [OUT_LEN_W-1:0] remaining_length;
  logic [OUT_LEN_W-1:0] leftover_factor;
  logic                 invalid_length;
  logic                 last_result;

  logic [LEN_W-1:0] pending_lengths [$];
  factor_result_t   expected_factors [$];
  radix_t           radix_tab [NUM_REGS];
  factor_result_t   want;
  bit               no_gaps = 1'b0;
  bit               drive_now;
  int               gap_left = 0;
  int               idle_cycles = 0;
  int               fail_count = 0;
  int               lengths_sent = 0;
  int               results_checked = 0;
  int               zero_lengths = 0;
  int               reg_writes = 0;

  mixed_radix_length_factorizer_core dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .fft_length       (fft_length),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .result_valid     (result_valid),
    .radix_index      (radix_index),
    .radix_count      (radix_count),
    .remaining_length (remaining_length),
    .leftover_factor  (leftover_factor),
    .invalid_length   (invalid_length),
    .last_result      (last_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned eff_radix(input int i);
    return (radix_tab[i] < RADIX_MIN) ? longint'(RADIX_MIN) : longint'(radix_tab[i]);
  endfunction

  function automatic void factor_length(input logic [LEN_W-1:0] len);
    longint unsigned rem;
    longint unsigned r;
    factor_result_t  res;
    bit              bad;
    rem = len;
    bad = (len == '0);
    for (int i = 0; i < RES_PER_LEN; i++) begin
      r = eff_radix(i);
      res = '0;
      res.idx = IDX_W'(i);
      if (!bad) begin
        while (rem % r == 0) begin
          rem = rem / r;
          res.count = res.count + 1'b1;
        end
        res.remain = OUT_LEN_W'(rem);
      end
      res.last = (i == RES_PER_LEN - 1);
      if (res.last && !bad) res.leftover = OUT_LEN_W'(rem);
      res.invalid = bad;
      expected_factors.push_back(res);
    end
  endfunction

  // mostly products of the current radices so the divider loops deep
  function automatic logic [LEN_W-1:0] random_length();
    longint unsigned v;
    longint unsigned r;
    int              kind;
    kind = $urandom_range(0, 19);
    v = 1;
    if (kind < 12) begin
      repeat ($urandom_range(0, 10)) begin
        r = eff_radix($urandom_range(0, RES_PER_LEN - 1));
        if (v * r < LEN_LIMIT) v = v * r;
      end
      r = $urandom_range(1, 64);
      if (v * r < LEN_LIMIT) v = v * r;
    end else if (kind < 15) begin
      v = $urandom() & (LEN_LIMIT - 1);
    end else if (kind == 15) begin
      v = 0;
    end else if (kind == 16) begin
      v = LEN_LIMIT - 1;
    end else begin
      v = $urandom_range(1, 1000);
    end
    return LEN_W'(v);
  endfunction

  function automatic radix_t random_radix();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return radix_t'($urandom_range(0, 1));
    if (pick < 3) return radix_t'($urandom_range(2, 255));
    return radix_t'($urandom_range(2, 16));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic write_radix(input reg_idx_t idx, input radix_t data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx < NUM_REGS) radix_tab[idx] = data;
    reg_writes++;
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_lengths.size() != 0 || start || busy || expected_factors.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      drive_now = start;
      if (start && !busy) begin
        factor_length(fft_length);
        lengths_sent++;
        if (fft_length == '0) zero_lengths++;
        drive_now = 1'b0;
        gap_left = no_gaps ? 0 : $urandom_range(0, 8);
      end else if (!start && gap_left > 0) begin
        gap_left--;
      end
      if (!drive_now && gap_left == 0 && pending_lengths.size() != 0) begin
        fft_length <= pending_lengths.pop_front();
        drive_now = 1'b1;
      end
      start <= drive_now;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_factors.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, radix_index %0d", radix_index));
      end else begin
        want = expected_factors.pop_front();
        results_checked++;
        if (radix_index !== want.idx)
          report_mismatch($sformatf("radix_index got %0d want %0d", radix_index, want.idx));
        if (radix_count !== want.count)
          report_mismatch($sformatf("radix_count[%0d] got %0d want %0d",
                                    want.idx, radix_count, want.count));
        if (remaining_length !== want.remain)
          report_mismatch($sformatf("remaining_length[%0d] got %0d want %0d",
                                    want.idx, remaining_length, want.remain));
        if (leftover_factor !== want.leftover)
          report_mismatch($sformatf("leftover_factor[%0d] got %0d want %0d",
                                    want.idx, leftover_factor, want.leftover));
        if (invalid_length !== want.invalid)
          report_mismatch($sformatf("invalid_length[%0d] got %0b want %0b",
                                    want.idx, invalid_length, want.invalid));
        if (last_result !== want.last)
          report_mismatch($sformatf("last_result[%0d] got %0b want %0b",
                                    want.idx, last_result, want.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < NUM_REGS; i++) radix_tab[i] = RADIX_RESET[i];
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset radices
    foreach (DIRECTED_DEFAULT[i]) pending_lengths.push_back(LEN_W'(DIRECTED_DEFAULT[i]));
    drain();

    // radices below two, top value, repeated radix, unused indexes
    write_radix(REG_RADIX_A, 8'd0);
    write_radix(REG_RADIX_B, 8'd1);
    write_radix(REG_RADIX_C, 8'd255);
    write_radix(REG_RADIX_D, 8'd4);
    write_radix(REG_RADIX_E, 8'd2);
    write_radix(REG_RADIX_F, 8'd254);
    write_radix(REG_SPARE_6, 8'd3);
    write_radix(REG_SPARE_7, 8'd255);
    end_writes();
    no_gaps = 1'b1;
    foreach (DIRECTED_ODD[i]) pending_lengths.push_back(LEN_W'(DIRECTED_ODD[i]));
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (p == 0) write_radix(reg_idx_t'(i), 8'd255);
        else if (p == 1) write_radix(reg_idx_t'(i), 8'd0);
        else write_radix(reg_idx_t'(i), random_radix());
      end
      if ($urandom_range(0, 1))
        write_radix(reg_idx_t'($urandom_range(NUM_REGS, 7)), radix_t'($urandom()));
      end_writes();
      no_gaps = (p % 3 == 2);
      repeat (RAND_ITEMS) pending_lengths.push_back(random_length());
      drain();
    end

    repeat (20) @(negedge clk);
    if (expected_factors.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_factors.size()));
    $display("covered %0d lengths (%0d zero), %0d results checked, %0d register writes",
             lengths_sent, zero_lengths, results_checked, reg_writes);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
